// ===== rtl/core/asl_pkg.sv =====
// Shared types, constants and command codes of the actuator slew limiter.
`default_nettype none
package asl_pkg;

  localparam int PULSE_W      = 12;
  localparam int CMD_W        = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CHANNELS_DEF = 4;
  localparam int CHANNELS_MAX = 8;

  typedef logic [PULSE_W-1:0] pulse_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE   = 3'd0,
    CMD_ARM      = 3'd1,
    CMD_DISARM   = 3'd2,
    CMD_FS_BLOCK = 3'd3,
    CMD_FS_CLEAR = 3'd4,
    CMD_SAFE     = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVO_MIN     = 3'd0,
    REG_SERVO_MAX     = 3'd1,
    REG_SERVO_NEUTRAL = 3'd2,
    REG_MOTOR_STOP    = 3'd3,
    REG_MOTOR_MAX     = 3'd4,
    REG_MOTOR_ARM     = 3'd5,
    REG_SLEW_SERVO    = 3'd6,
    REG_SLEW_MOTOR    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    pulse_t servo_min;
    pulse_t servo_max;
    pulse_t servo_neutral;
    pulse_t motor_stop;
    pulse_t motor_max;
    pulse_t motor_arm;
    pulse_t slew_servo;
    pulse_t slew_motor;
  } cfg_t;

  typedef struct packed {
    logic armed;
    logic failsafe;
  } flags_t;

  localparam cfg_t CFG_RESET = '{
    servo_min:     12'd1000,
    servo_max:     12'd2000,
    servo_neutral: 12'd1500,
    motor_stop:    12'd1000,
    motor_max:     12'd2000,
    motor_arm:     12'd1000,
    slew_servo:    12'd50,
    slew_motor:    12'd20
  };

endpackage
`default_nettype wire

// ===== rtl/core/asl_if.sv =====
// Channel interfaces: command beats, result beats and register writes.
`default_nettype none
interface asl_req_if;
  logic                  valid;
  logic                  ready;
  logic [asl_pkg::CMD_W-1:0] cmd;
  asl_pkg::pulse_t       target_wing_r;
  asl_pkg::pulse_t       target_wing_l;
  asl_pkg::pulse_t       target_rudder;
  asl_pkg::pulse_t       target_motor;

  modport source (output valid, cmd, target_wing_r, target_wing_l, target_rudder,
                  target_motor, input ready);
  modport sink (input valid, cmd, target_wing_r, target_wing_l, target_rudder,
                target_motor, output ready);
endinterface

interface asl_rsp_if;
  logic            valid;
  logic            ready;
  asl_pkg::pulse_t pulse_wing_r;
  asl_pkg::pulse_t pulse_wing_l;
  asl_pkg::pulse_t pulse_rudder;
  asl_pkg::pulse_t pulse_motor;
  logic            is_armed;
  logic            in_failsafe;
  logic            was_applied;

  modport source (output valid, pulse_wing_r, pulse_wing_l, pulse_rudder, pulse_motor,
                  is_armed, in_failsafe, was_applied, input ready);
  modport sink (input valid, pulse_wing_r, pulse_wing_l, pulse_rudder, pulse_motor,
                is_armed, in_failsafe, was_applied, output ready);
endinterface

interface asl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [asl_pkg::CFG_IDX_W-1:0] index;
  asl_pkg::pulse_t               data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/asl_lane.sv =====
// One channel lane: clamp the target to the limits, then step toward it.
`default_nettype none
module asl_lane (
  input  asl_pkg::pulse_t cur,
  input  asl_pkg::pulse_t target,
  input  asl_pkg::pulse_t lo,
  input  asl_pkg::pulse_t hi,
  input  asl_pkg::pulse_t step,
  output asl_pkg::pulse_t result
);

  asl_pkg::pulse_t clamped;
  asl_pkg::pulse_t up_gap;
  asl_pkg::pulse_t down_gap;

  // With inverted limits, a target below the low limit gives the low limit and any other target the high limit.
  always_comb begin
    if (target < lo) begin
      clamped = lo;
    end else if (target > hi) begin
      clamped = hi;
    end else begin
      clamped = target;
    end
  end

  assign up_gap   = clamped - cur;
  assign down_gap = cur - clamped;

  // cur + step stays below clamped and cur - step above it, so neither side can wrap.
  always_comb begin
    if (clamped > cur) begin
      result = (up_gap <= step) ? clamped : cur + step;
    end else if (clamped < cur) begin
      result = (down_gap <= step) ? clamped : cur - step;
    end else begin
      result = cur;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/asl_merge.sv =====
// Command decode: pick lane results, safe position or hold, and update the flags.
`default_nettype none
module asl_merge #(
  parameter int CHANNELS = asl_pkg::CHANNELS_DEF
) (
  input  logic [asl_pkg::CMD_W-1:0] cmd,
  input  asl_pkg::flags_t           flags,
  input  asl_pkg::pulse_t           cur [CHANNELS],
  input  asl_pkg::pulse_t           lane_result [CHANNELS],
  input  asl_pkg::pulse_t           servo_neutral,
  input  asl_pkg::pulse_t           motor_stop,
  output asl_pkg::pulse_t           pulse_next [CHANNELS],
  output asl_pkg::flags_t           flags_next,
  output logic                      applied
);

  localparam int MOTOR = CHANNELS - 1;

  logic write_all;
  logic write_motor;
  logic go_safe;

  always_comb begin
    write_all   = 1'b0;
    write_motor = 1'b0;
    go_safe     = 1'b0;
    applied     = 1'b0;
    flags_next  = flags;
    case (asl_pkg::cmd_t'(cmd))
      asl_pkg::CMD_UPDATE: begin
        if (flags.armed && !flags.failsafe) begin
          write_all = 1'b1;
          applied   = 1'b1;
        end
      end
      asl_pkg::CMD_ARM: begin
        if (!flags.failsafe && !flags.armed) begin
          write_motor      = 1'b1;
          flags_next.armed = 1'b1;
          applied          = 1'b1;
        end
      end
      asl_pkg::CMD_DISARM: begin
        // Failsafe stays set; only the pulses and the arm flag drop.
        if (flags.armed || flags.failsafe) begin
          go_safe          = 1'b1;
          flags_next.armed = 1'b0;
          applied          = 1'b1;
        end
      end
      asl_pkg::CMD_FS_BLOCK: begin
        if (!flags.failsafe) begin
          go_safe             = 1'b1;
          flags_next.armed    = 1'b0;
          flags_next.failsafe = 1'b1;
          applied             = 1'b1;
        end
      end
      asl_pkg::CMD_FS_CLEAR: begin
        if (flags.failsafe) begin
          go_safe             = 1'b1;
          flags_next.armed    = 1'b0;
          flags_next.failsafe = 1'b0;
          applied             = 1'b1;
        end
      end
      asl_pkg::CMD_SAFE: begin
        go_safe = 1'b1;
        applied = 1'b1;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    always_comb begin
      if (go_safe) begin
        pulse_next[g] = (g == MOTOR) ? motor_stop : servo_neutral;
      end else if (write_all || (write_motor && (g == MOTOR))) begin
        pulse_next[g] = lane_result[g];
      end else begin
        pulse_next[g] = cur[g];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/actuator_slew_limiter_with_arming_core.sv =====
// Top level of the actuator slew limiter with arming and failsafe.
// Drives CHANNELS stored pulse widths (last channel is the motor, the rest
// servos) and answers every command beat with one result beat that carries the
// pulses and flags after the command. Each channel has its own clamp-and-slew
// lane and all lanes run in the same cycle, so a command is taken every clock
// unless the result port stalls. The result is registered, and a new command is
// accepted while the previous result sits in the output register if that result
// is taken in the same cycle. Register writes go through a separate always-ready
// port and are meant for idle periods; they take effect on the next command.
`default_nettype none
module actuator_slew_limiter_with_arming_core #(
  parameter int CHANNELS = asl_pkg::CHANNELS_DEF
) (
  input logic       clk,
  input logic       rst,
  asl_cfg_if.sink   cfg,
  asl_req_if.sink   req,
  asl_rsp_if.source rsp
);

  localparam int MOTOR = CHANNELS - 1;

  asl_pkg::cfg_t   regs;
  asl_pkg::pulse_t pulse [CHANNELS];
  asl_pkg::pulse_t pulse_next [CHANNELS];
  asl_pkg::pulse_t lane_result [CHANNELS];
  asl_pkg::flags_t flags;
  asl_pkg::flags_t flags_next;
  logic            applied;
  logic            accept;
  asl_pkg::pulse_t map_wing_r;
  asl_pkg::pulse_t map_wing_l;
  asl_pkg::pulse_t map_rudder;

  assign cfg.ready = 1'b1;
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= asl_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      case (asl_pkg::reg_idx_t'(cfg.index))
        asl_pkg::REG_SERVO_MIN:     regs.servo_min     <= cfg.data;
        asl_pkg::REG_SERVO_MAX:     regs.servo_max     <= cfg.data;
        asl_pkg::REG_SERVO_NEUTRAL: regs.servo_neutral <= cfg.data;
        asl_pkg::REG_MOTOR_STOP:    regs.motor_stop    <= cfg.data;
        asl_pkg::REG_MOTOR_MAX:     regs.motor_max     <= cfg.data;
        asl_pkg::REG_MOTOR_ARM:     regs.motor_arm     <= cfg.data;
        asl_pkg::REG_SLEW_SERVO:    regs.slew_servo    <= cfg.data;
        asl_pkg::REG_SLEW_MOTOR:    regs.slew_motor    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    asl_pkg::pulse_t target;
    asl_pkg::pulse_t lo;
    asl_pkg::pulse_t hi;
    asl_pkg::pulse_t step;

    if (g == MOTOR) begin : g_motor
      // Arm drives the motor lane with the arm pulse instead of the target.
      assign target = (asl_pkg::cmd_t'(req.cmd) == asl_pkg::CMD_ARM) ?
                      regs.motor_arm : req.target_motor;
      assign lo     = regs.motor_stop;
      assign hi     = regs.motor_max;
      assign step   = regs.slew_motor;
    end else begin : g_servo
      if (g == 0) begin : g_wr
        assign target = req.target_wing_r;
      end else if (g == 1) begin : g_wl
        assign target = req.target_wing_l;
      end else begin : g_rud
        assign target = req.target_rudder;
      end
      assign lo   = regs.servo_min;
      assign hi   = regs.servo_max;
      assign step = regs.slew_servo;
    end

    asl_lane u_lane (
      .cur    (pulse[g]),
      .target (target),
      .lo     (lo),
      .hi     (hi),
      .step   (step),
      .result (lane_result[g])
    );
  end

  asl_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .cmd           (req.cmd),
    .flags         (flags),
    .cur           (pulse),
    .lane_result   (lane_result),
    .servo_neutral (regs.servo_neutral),
    .motor_stop    (regs.motor_stop),
    .pulse_next    (pulse_next),
    .flags_next    (flags_next),
    .applied       (applied)
  );

  // Servo fields with no servo channel behind them read as zero.
  if (MOTOR > 0) begin : g_map_wr
    assign map_wing_r = pulse_next[0];
  end else begin : g_zero_wr
    assign map_wing_r = '0;
  end
  if (MOTOR > 1) begin : g_map_wl
    assign map_wing_l = pulse_next[1];
  end else begin : g_zero_wl
    assign map_wing_l = '0;
  end
  if (MOTOR > 2) begin : g_map_rud
    assign map_rudder = pulse_next[2];
  end else begin : g_zero_rud
    assign map_rudder = '0;
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_state
    always_ff @(posedge clk) begin
      if (rst) begin
        pulse[g] <= (g == MOTOR) ? asl_pkg::CFG_RESET.motor_stop :
                                   asl_pkg::CFG_RESET.servo_neutral;
      end else if (accept) begin
        pulse[g] <= pulse_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        flags     <= flags_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Load the result beat; hold it while the sink stalls.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.pulse_wing_r <= map_wing_r;
      rsp.pulse_wing_l <= map_wing_l;
      rsp.pulse_rudder <= map_rudder;
      rsp.pulse_motor  <= pulse_next[MOTOR];
      rsp.is_armed     <= flags_next.armed;
      rsp.in_failsafe  <= flags_next.failsafe;
      rsp.was_applied  <= applied;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(flags.armed && flags.failsafe))
    else $error("armed and failsafe set together");

  a_safe_applied: assert property (@(posedge clk) disable iff (rst)
    (accept && (asl_pkg::cmd_t'(req.cmd) == asl_pkg::CMD_SAFE)) |=>
      (rsp.valid && rsp.was_applied && (rsp.pulse_motor == regs.motor_stop)))
    else $error("safe position not applied");

  a_block_sets_failsafe: assert property (@(posedge clk) disable iff (rst)
    (accept && (asl_pkg::cmd_t'(req.cmd) == asl_pkg::CMD_FS_BLOCK)) |=>
      (flags.failsafe && !flags.armed && rsp.in_failsafe))
    else $error("failsafe block did not take hold");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.pulse_motor == pulse[MOTOR]) &&
                   (rsp.is_armed == flags.armed) &&
                   (rsp.in_failsafe == flags.failsafe)))
    else $error("result beat differs from stored state");

endmodule
`default_nettype wire
